// File: rtl/mpsm_pkg.sv
`default_nettype none
package mpsm_pkg;

  localparam int PAT_BYTES  = 16;
  localparam int LEN_W      = 5;
  localparam int POS_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PAT_LOW  = 3'd0;
  localparam cfg_idx_t CFG_PAT_HIGH = 3'd1;
  localparam cfg_idx_t CFG_CARE     = 3'd2;
  localparam cfg_idx_t CFG_LENGTH   = 3'd3;
  localparam cfg_idx_t CFG_BASE     = 3'd4;

  typedef logic [1:0] outcome_t;

  localparam outcome_t OUT_NONE = 2'd0;
  localparam outcome_t OUT_ONE  = 2'd1;
  localparam outcome_t OUT_MANY = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]     length;
    logic [PAT_BYTES-1:0] care;
    logic [63:0]          high;
    logic [63:0]          low;
  } pat_cfg_t;

endpackage
`default_nettype wire

// File: rtl/mpsm_match.sv
`default_nettype none
// Masked compare of the window against the pattern; window entry 0 is the newest byte,
// pattern byte k lines up with window entry length-1-k.
module mpsm_match #(
  parameter int WIN = 16
) (
  input  logic [7:0]         win [WIN],
  input  mpsm_pkg::pat_cfg_t pat,
  output logic               hit
);

  localparam int IW = (WIN > 1) ? $clog2(WIN) : 1;

  always_comb begin
    logic [8*mpsm_pkg::PAT_BYTES-1:0] pbytes;
    logic [mpsm_pkg::LEN_W-1:0]       idx;
    logic [7:0]                       wbyte;
    logic                             any_care;
    logic                             all_eq;
    logic                             in_use;
    pbytes   = {pat.high, pat.low};
    any_care = 1'b0;
    all_eq   = 1'b1;
    for (int k = 0; k < mpsm_pkg::PAT_BYTES; k++) begin
      in_use = mpsm_pkg::LEN_W'(k) < pat.length;
      idx    = pat.length - mpsm_pkg::LEN_W'(1) - mpsm_pkg::LEN_W'(k);
      wbyte  = 8'h00;
      if (in_use && (32'(idx) < WIN)) begin
        wbyte = win[idx[IW-1:0]];
      end
      if (in_use && pat.care[k]) begin
        any_care = 1'b1;
        if (wbyte != pbytes[8*k +: 8]) begin
          all_eq = 1'b0;
        end
      end
    end
    hit = any_care && all_eq;
  end

endmodule
`default_nettype wire

// File: rtl/masked_pattern_sole_match_scan.sv
// Masked byte pattern scan with a sole-match result.
// Input stream s_*: one region byte per word in s_tdata[7:0]; s_tlast marks the final
// byte. Output stream m_*: one word per region, sent after the final byte; m_tdata holds
// the matched address (region base plus offset) when exactly one match was found, else
// zero; m_tuser holds the outcome (0 none, 1 one, 2 several).
// Config channel cfg_*: index 0 pattern bytes 0..7, 1 pattern bytes 8..15, 2 care mask,
// 3 pattern length, 4 region base. cfg_ready is always high; write only while idle.
// Throughput is one byte per cycle while s_tready is high: an input register feeds a single
// compare stage that updates the window, position and match tally, then loads the result
// register. m_tvalid is set in that register once the final byte passes the compare stage.
// A stalled result holds in the output register; the input side keeps taking bytes until
// another final byte would need that register, then s_tready drops.
// Reset clears the configuration to its defaults (length 1) and starts a new region.
`default_nettype none
module masked_pattern_sole_match_scan #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int STEP_BYTES        = 4,
  parameter int ADDRESS_BITS      = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tlast,   // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mpsm_pkg::POS_W-1:0]        m_tdata,   // [47:0] found_address
  output logic [1:0]                        m_tuser,   // [1:0] outcome
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int POS_W = mpsm_pkg::POS_W;
  localparam int LEN_W = mpsm_pkg::LEN_W;
  localparam int WIN   = (MAX_PATTERN_BYTES < mpsm_pkg::PAT_BYTES) ?
                         MAX_PATTERN_BYTES : mpsm_pkg::PAT_BYTES;
  localparam int PH_W  = (STEP_BYTES > 1) ? $clog2(STEP_BYTES) : 1;
  localparam logic [POS_W-1:0] ADDR_MASK = (ADDRESS_BITS >= POS_W) ? {POS_W{1'b1}} :
                                           ((POS_W'(1) << ADDRESS_BITS) - POS_W'(1));

  // configuration
  mpsm_pkg::pat_cfg_t   pat;
  logic [POS_W-1:0]     base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat.low    <= '0;
      pat.high   <= '0;
      pat.care   <= '0;
      pat.length <= LEN_W'(1);
      base       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpsm_pkg::CFG_PAT_LOW:  pat.low    <= cfg_data;
        mpsm_pkg::CFG_PAT_HIGH: pat.high   <= cfg_data;
        mpsm_pkg::CFG_CARE:     pat.care   <= cfg_data[mpsm_pkg::PAT_BYTES-1:0];
        mpsm_pkg::CFG_LENGTH:   pat.length <= cfg_data[LEN_W-1:0];
        mpsm_pkg::CFG_BASE:     base       <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       go;

  assign go       = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata[7:0];
      in_last <= s_tlast;
    end
  end

  // scan state
  logic [7:0]             win      [WIN];
  logic [7:0]             win_next [WIN];
  logic [POS_W-1:0]       pos;
  logic [PH_W-1:0]        phase;
  logic [POS_W-1:0]       match_off;
  mpsm_pkg::outcome_t     tally;
  logic [PH_W-1:0]        len_phase [mpsm_pkg::PAT_BYTES];

  // (length-1) mod step for every length
  for (genvar g = 0; g < mpsm_pkg::PAT_BYTES; g++) begin : g_lph
    assign len_phase[g] = PH_W'(g % STEP_BYTES);
  end

  always_comb begin
    win_next[0] = in_byte;
    for (int i = 1; i < WIN; i++) begin
      win_next[i] = win[i-1];
    end
  end

  logic hit;

  mpsm_match #(.WIN(WIN)) u_match (
    .win (win_next),
    .pat (pat),
    .hit (hit)
  );

  logic [LEN_W-1:0]   len_m1;
  logic               len_ok;
  logic               aligned;
  logic               found;
  logic [POS_W-1:0]   start;
  logic [POS_W-1:0]   match_off_next;
  mpsm_pkg::outcome_t tally_next;
  logic [PH_W-1:0]    phase_next;
  logic [POS_W-1:0]   sum;

  always_comb begin
    len_m1  = pat.length - LEN_W'(1);
    len_ok  = (pat.length != '0) && (32'(pat.length) <= WIN);
    aligned = (phase == len_phase[len_m1[3:0]]);
    found   = len_ok && (pos >= POS_W'(len_m1)) && aligned && hit;
    start   = pos - POS_W'(len_m1);

    match_off_next = match_off;
    tally_next     = tally;
    if (found) begin
      match_off_next = start;
      if (tally != mpsm_pkg::OUT_MANY) begin
        tally_next = tally + 2'd1;
      end
    end

    if ((phase == PH_W'(STEP_BYTES - 1)) || (pos == {POS_W{1'b1}})) begin
      phase_next = '0;
    end else begin
      phase_next = phase + PH_W'(1);
    end

    sum = (base + match_off_next) & ADDR_MASK;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < WIN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= '0;
      match_off <= '0;
      tally     <= mpsm_pkg::OUT_NONE;
    end else if (go) begin
      if (in_last) begin
        pos       <= '0;
        phase     <= '0;
        match_off <= '0;
        tally     <= mpsm_pkg::OUT_NONE;
      end else begin
        pos       <= pos + POS_W'(1);
        phase     <= phase_next;
        match_off <= match_off_next;
        tally     <= tally_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_last) begin
      m_tdata <= (tally_next == mpsm_pkg::OUT_ONE) ? sum : '0;
      m_tuser <= tally_next;
    end
  end

endmodule
`default_nettype wire
